[hdl/pdqs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pdqs_pkg
// Types and constants shared by the point deque with magnitude search/sort.
// ----------------------------------------------------------------------------
package pdqs_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int COORD_W = 16;
    localparam int SQ_W    = 2 * COORD_W - 1;
    localparam int MAG_W   = 32;
    localparam int OP_W    = 4;
    localparam int STAT_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_POP_BACK   = 4'd1,
        OP_PUSH_FRONT = 4'd2,
        OP_POP_FRONT  = 4'd3,
        OP_COUNT      = 4'd4,
        OP_CLEAR      = 4'd5,
        OP_FARTHEST   = 4'd6,
        OP_NEAREST    = 4'd7,
        OP_SORT_UP    = 4'd8,
        OP_SORT_DOWN  = 4'd9
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

endpackage

`default_nettype wire

[hdl/pdqs_sqmag.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pdqs_sqmag
// Squared magnitude unit: squares registered, sum taken from the registers.
// ----------------------------------------------------------------------------
module pdqs_sqmag
(
    input  wire logic           clk,
    input  wire pdqs_pkg::point_t pt,
    output logic [pdqs_pkg::MAG_W-1:0] mag
);
    import pdqs_pkg::*;

    logic signed [2*COORD_W-1:0] prod_x;
    logic signed [2*COORD_W-1:0] prod_y;
    logic signed [2*COORD_W-1:0] prod_z;
    logic [SQ_W-1:0] sqx_reg;
    logic [SQ_W-1:0] sqy_reg;
    logic [SQ_W-1:0] sqz_reg;

    // full-width signed products, never negative
    assign prod_x = pt.x * pt.x;
    assign prod_y = pt.y * pt.y;
    assign prod_z = pt.z * pt.z;

    // one square per coordinate, registered
    always_ff @(posedge clk)
    begin
        sqx_reg <= SQ_W'(unsigned'(prod_x));
        sqy_reg <= SQ_W'(unsigned'(prod_y));
        sqz_reg <= SQ_W'(unsigned'(prod_z));
    end

    // sum of the three squares, never exceeds 32 bits
    assign mag = MAG_W'(sqx_reg) + MAG_W'(sqy_reg) + MAG_W'(sqz_reg);

endmodule

`default_nettype wire

[hdl/point_deque_with_magnitude_search_sort.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// point_deque_with_magnitude_search_sort
// Bounded deque of 3D points with nearest/farthest search and stable sort.
// ----------------------------------------------------------------------------
// Points live in a 16-entry circular buffer in one synchronous RAM, addressed
// through a head pointer so pushes at either end are single writes and pops
// only move the pointer and count. Push, pop, count and clear are handled in
// the idle state; the result is then held in the output register until
// taken, and the next item is accepted once it has gone. Every RAM read
// passes through three steps (read, square, compare); a search reads each
// held point once. Sorting is an insertion sort through the RAM: each key
// is read, each entry it passes moves up one place, then the key is stored.
// ----------------------------------------------------------------------------
module point_deque_with_magnitude_search_sort
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [pdqs_pkg::OP_W-1:0]         operation,
    input  wire logic signed [pdqs_pkg::COORD_W-1:0] in_x,
    input  wire logic signed [pdqs_pkg::COORD_W-1:0] in_y,
    input  wire logic signed [pdqs_pkg::COORD_W-1:0] in_z,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [pdqs_pkg::STAT_W-1:0]            status,
    output logic [pdqs_pkg::CNT_W-1:0]             count,
    output logic signed [pdqs_pkg::COORD_W-1:0]    out_x,
    output logic signed [pdqs_pkg::COORD_W-1:0]    out_y,
    output logic signed [pdqs_pkg::COORD_W-1:0]    out_z,
    output logic [pdqs_pkg::MAG_W-1:0]             square_magnitude
);
    import pdqs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_MUL  = 5'b00100,
        S_USE  = 5'b01000,
        S_PUT  = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_KEY    = 2'd1,
        PH_SCAN   = 2'd2
    } phase_t;

    // point storage
    point_t mem [DEPTH];
    point_t rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    point_t           wr_data;

    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic             far_reg, far_next;
    logic             down_reg, down_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] j_reg, j_next;
    point_t           key_reg, key_next;
    logic [MAG_W-1:0] km_reg, km_next;
    point_t           best_reg, best_next;
    logic [MAG_W-1:0] bm_reg, bm_next;

    logic             out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [CNT_W-1:0] count_reg, count_next;
    point_t           outp_reg, outp_next;
    logic [MAG_W-1:0] mag_reg, mag_next;

    logic             accept;
    op_t              op;
    point_t           in_pt;
    logic [MAG_W-1:0] mag;
    logic             better;
    logic             move;
    logic             last_i;

    assign op       = op_t'(operation);
    assign in_pt    = '{x: in_x, y: in_y, z: in_z};
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign accept   = in_valid && !in_stall;

    // squared magnitude of the entry just read
    pdqs_sqmag u_sqmag
    (
        .clk (clk),
        .pt  (rd_data_reg),
        .mag (mag)
    );

    assign better = (idx_reg == '0) || (far_reg ? (mag > bm_reg) : (mag < bm_reg));
    assign move   = down_reg ? (mag < km_reg) : (mag > km_reg);
    assign last_i = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;

    // RAM write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        far_next       = far_reg;
        down_next      = down_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        key_next       = key_reg;
        km_next        = km_reg;
        best_next      = best_reg;
        bm_next        = bm_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        count_next     = count_reg;
        outp_next      = outp_reg;
        mag_next       = mag_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = in_pt;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next    = ST_OK;
                    outp_next      = '0;
                    mag_next       = '0;
                    out_valid_next = 1'b1;
                    case (op)
                        OP_PUSH_BACK:
                        begin
                            if (cnt_reg == CNT_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = head_reg + cnt_reg[IDX_W-1:0];
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            if (cnt_reg == CNT_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = head_reg - IDX_W'(1);
                                head_next = head_reg - IDX_W'(1);
                                cnt_next  = cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_POP_BACK, OP_POP_FRONT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - CNT_W'(1);
                                if (op == OP_POP_FRONT)
                                begin
                                    head_next = head_reg + IDX_W'(1);
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        OP_FARTHEST, OP_NEAREST:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                far_next       = (op == OP_FARTHEST);
                                phase_next     = PH_SEARCH;
                                idx_next       = '0;
                                state_next     = S_RD;
                            end
                        end
                        OP_SORT_UP, OP_SORT_DOWN:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (cnt_reg != CNT_W'(1))
                            begin
                                out_valid_next = 1'b0;
                                down_next      = (op == OP_SORT_DOWN);
                                phase_next     = PH_KEY;
                                idx_next       = IDX_W'(1);
                                state_next     = S_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    count_next = cnt_next;
                end
            end
            S_RD:
            begin
                rd_en = 1'b1;
                case (phase_reg)
                    PH_SCAN: rd_addr = head_reg + j_reg - IDX_W'(1);
                    default: rd_addr = head_reg + idx_reg;
                endcase
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_USE;
            end
            S_USE:
            begin
                case (phase_reg)
                    PH_SEARCH:
                    begin
                        if (better)
                        begin
                            best_next = rd_data_reg;
                            bm_next   = mag;
                        end
                        if (last_i)
                        begin
                            status_next    = ST_OK;
                            count_next     = cnt_reg;
                            outp_next      = best_next;
                            mag_next       = bm_next;
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = S_RD;
                        end
                    end
                    PH_KEY:
                    begin
                        key_next   = rd_data_reg;
                        km_next    = mag;
                        j_next     = idx_reg;
                        phase_next = PH_SCAN;
                        state_next = S_RD;
                    end
                    default:
                    begin
                        if (move)
                        begin
                            // shift the entry that must move up one place
                            wr_en   = 1'b1;
                            wr_addr = head_reg + j_reg;
                            wr_data = rd_data_reg;
                            j_next  = j_reg - IDX_W'(1);
                            state_next = (j_reg == IDX_W'(1)) ? S_PUT : S_RD;
                        end
                        else
                        begin
                            state_next = S_PUT;
                        end
                    end
                endcase
            end
            S_PUT:
            begin
                // drop the key into its slot
                wr_en   = 1'b1;
                wr_addr = head_reg + j_reg;
                wr_data = key_reg;
                if (last_i)
                begin
                    status_next    = ST_OK;
                    count_next     = cnt_reg;
                    outp_next      = '0;
                    mag_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    phase_next = PH_KEY;
                    state_next = S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        phase_reg  <= phase_next;
        far_reg    <= far_next;
        down_reg   <= down_next;
        idx_reg    <= idx_next;
        j_reg      <= j_next;
        key_reg    <= key_next;
        km_reg     <= km_next;
        best_reg   <= best_next;
        bm_reg     <= bm_next;
        status_reg <= status_next;
        count_reg  <= count_next;
        outp_reg   <= outp_next;
        mag_reg    <= mag_next;
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign count            = count_reg;
    assign out_x            = outp_reg.x;
    assign out_y            = outp_reg.y;
    assign out_z            = outp_reg.z;
    assign square_magnitude = mag_reg;

endmodule

`default_nettype wire
